// ----- rtl/core/sll_pkg.sv -----
// Shared types, widths and codes for the singly linked list engine.
package sll_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int LEN_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 9;
  localparam int CMP_W       = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef logic [VALUE_WIDTH-1:0] cell_val_t;
  typedef logic [IDX_W-1:0]       cell_idx_t;
  typedef logic [LEN_W-1:0]       list_len_t;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_DEL_HEAD = 3'd3,
    REQ_DEL_TAIL = 3'd4,
    REQ_DEL_POS  = 3'd5,
    REQ_SEARCH   = 3'd6,
    REQ_READ     = 3'd7
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t  op;
    cell_idx_t tgt;
    cell_idx_t last;
    cell_val_t ins_val;
  } cell_cmd_t;

  typedef struct packed {
    req_type_t          req_type;
    logic signed [31:0] item_value;
    logic [8:0]         position;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic [8:0]         found_position;
    logic signed [31:0] read_value;
    logic [8:0]         list_length;
  } out_rsp_t;

endpackage

// ----- rtl/core/sll_cell.sv -----
// One list cell: holds the element at its position and trades it with its neighbors.
module sll_cell import sll_pkg::*; (
  input  logic      clk,
  input  cell_idx_t cell_index,
  input  cell_cmd_t cmd,
  input  cell_val_t left_val,
  input  cell_val_t right_val,
  input  cell_val_t head_val,
  output cell_val_t val_out
);

  cell_val_t val_r;
  cell_val_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      CELL_HOLD: begin
        val_nxt = val_r;
      end
      CELL_ROTATE: begin
        // ring of the live cells: the last one wraps to the head
        val_nxt = (cell_index == cmd.last) ? head_val : right_val;
      end
      CELL_INSERT: begin
        if (cell_index == cmd.tgt) begin
          val_nxt = cmd.ins_val;
        end else if (cell_index > cmd.tgt) begin
          val_nxt = left_val;
        end
      end
      CELL_REMOVE: begin
        if (cell_index >= cmd.tgt) begin
          val_nxt = right_val;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_out = val_r;

endmodule

// ----- rtl/core/sll_ctrl.sv -----
// Request sequencer: checks, cell commands, scan over the ring and result register.
module sll_ctrl import sll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_req_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_rsp_t  out_data,
  input  cell_val_t head_val,
  output cell_cmd_t cell_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t    state_r;
  in_req_t   req_r;
  list_len_t length_r;
  cell_idx_t tgt_r;
  cell_idx_t cnt_r;
  status_t   status_r;
  logic [8:0] fpos_r;
  logic [31:0] rval_r;
  logic      out_valid_r;
  out_rsp_t  out_data_r;

  logic [CMP_W-1:0] cp;
  logic [CMP_W-1:0] cl;
  logic      full;
  logic      empty;
  logic      pos_bad_del;
  logic      pos_bad_ins;
  cell_idx_t pos_tgt;
  cell_idx_t last_idx;
  cell_val_t req_val;
  logic      is_delete;
  logic      is_search;
  logic      match;
  status_t   ev_status;
  logic      ev_insert;
  logic      ev_scan;
  cell_idx_t ev_tgt;

  always_comb begin
    cp          = CMP_W'(req_r.position);
    cl          = CMP_W'(length_r);
    full        = (length_r == LEN_W'(CAPACITY));
    empty       = (length_r == '0);
    pos_bad_del = (req_r.position == '0) || (cp > cl);
    pos_bad_ins = (req_r.position == '0) || (cp > cl + CMP_W'(1));
    pos_tgt     = cell_idx_t'(req_r.position - POS_W'(1));
    last_idx    = cell_idx_t'(length_r - LEN_W'(1));
    req_val     = cell_val_t'($unsigned(req_r.item_value));
    is_delete   = (req_r.req_type == REQ_DEL_HEAD) || (req_r.req_type == REQ_DEL_TAIL) ||
                  (req_r.req_type == REQ_DEL_POS);
    is_search   = (req_r.req_type == REQ_SEARCH);
    match       = (head_val == req_val);

    ev_status = ST_OK;
    ev_insert = 1'b0;
    ev_scan   = 1'b0;
    ev_tgt    = '0;
    unique case (req_r.req_type)
      REQ_INS_HEAD: begin
        if (full) ev_status = ST_FULL;
        else ev_insert = 1'b1;
      end
      REQ_INS_TAIL: begin
        if (full) begin
          ev_status = ST_FULL;
        end else begin
          ev_insert = 1'b1;
          ev_tgt    = cell_idx_t'(length_r);
        end
      end
      REQ_INS_POS: begin
        if (full) begin
          ev_status = ST_FULL;
        end else if (pos_bad_ins) begin
          ev_status = ST_RANGE;
        end else begin
          ev_insert = 1'b1;
          ev_tgt    = pos_tgt;
        end
      end
      REQ_DEL_HEAD: begin
        if (empty) ev_status = ST_EMPTY;
        else ev_scan = 1'b1;
      end
      REQ_DEL_TAIL: begin
        if (empty) begin
          ev_status = ST_EMPTY;
        end else begin
          ev_scan = 1'b1;
          ev_tgt  = last_idx;
        end
      end
      REQ_SEARCH: begin
        if (empty) begin
          ev_status = ST_EMPTY;
        end else begin
          ev_status = ST_NOT_FOUND;
          ev_scan   = 1'b1;
        end
      end
      REQ_DEL_POS, REQ_READ: begin
        if (empty) begin
          ev_status = ST_EMPTY;
        end else if (pos_bad_del) begin
          ev_status = ST_RANGE;
        end else begin
          ev_scan = 1'b1;
          ev_tgt  = pos_tgt;
        end
      end
    endcase
  end

  always_comb begin
    cell_cmd.op      = CELL_HOLD;
    cell_cmd.tgt     = tgt_r;
    cell_cmd.last    = last_idx;
    cell_cmd.ins_val = req_val;
    unique case (state_r)
      S_EVAL: begin
        cell_cmd.tgt = ev_tgt;
        if (ev_insert) cell_cmd.op = CELL_INSERT;
      end
      S_SCAN:  cell_cmd.op = CELL_ROTATE;
      S_SHIFT: cell_cmd.op = CELL_REMOVE;
      S_IDLE, S_FINISH: cell_cmd.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= '0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_FINISH reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_FINISH)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          status_r <= ev_status;
          fpos_r   <= '0;
          rval_r   <= '0;
          tgt_r    <= ev_tgt;
          cnt_r    <= '0;
          if (ev_insert) length_r <= length_r + LEN_W'(1);
          state_r  <= ev_scan ? S_SCAN : S_FINISH;
        end
        S_SCAN: begin
          // the head cell shows element cnt_r+1 while the ring turns once
          if (!is_search && (cnt_r == tgt_r)) rval_r <= 32'(head_val);
          if (is_search && (status_r == ST_NOT_FOUND) && match) begin
            status_r <= ST_OK;
            fpos_r   <= 9'(LEN_W'(cnt_r) + LEN_W'(1));
          end
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == last_idx) state_r <= is_delete ? S_SHIFT : S_FINISH;
        end
        S_SHIFT: begin
          length_r <= length_r - LEN_W'(1);
          state_r  <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.status          <= status_r;
            out_data_r.found_position  <= fpos_r;
            out_data_r.read_value      <= rval_r;
            out_data_r.list_length     <= 9'(length_r);
            state_r                    <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/singly_linked_list_engine.sv -----
// Top level of the singly linked list engine: sequencer and the row of list cells.
//
// Usage: one request per in_valid/in_stall handshake on in_data (type, value,
// position); one result per request on out_valid/out_stall with status,
// found position, value and list length after the request.
// Element n of the list sits in cell n-1 of a row of CAPACITY cells.
// Inserts shift the cells behind the insert point right. Read, search and
// delete turn the ring of live cells once, one cell per cycle, while the
// sequencer watches the head cell; a delete then shifts the cells behind
// the removed one left. One request is in work at a time; the next can
// be taken in the cycle after the result is loaded. A result waiting under
// out_stall does not block acceptance; the sequencer holds its next result
// until the output register frees up. Reset (rst_n low, synchronous)
// empties the list; cell contents are not cleared and are never read
// before written.
module singly_linked_list_engine import sll_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data
);

  cell_cmd_t cell_cmd;
  cell_val_t cell_vals [CAPACITY];

  sll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head_val  (cell_vals[0]),
    .cell_cmd  (cell_cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_val_t left_val;
    cell_val_t right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = cell_vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_vals[i];
    end else begin : g_inner_r
      assign right_val = cell_vals[i+1];
    end

    sll_cell u_cell (
      .clk        (clk),
      .cell_index (cell_idx_t'(i)),
      .cmd        (cell_cmd),
      .left_val   (left_val),
      .right_val  (right_val),
      .head_val   (cell_vals[0]),
      .val_out    (cell_vals[i])
    );
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in work");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |->
      ((out_data.read_value == '0) && (out_data.found_position == '0)))
    else $error("failed request returned a value or position");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |->
      (out_data.list_length == 9'(CAPACITY)))
    else $error("full status with list not at capacity");

  a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_EMPTY)) |-> (out_data.list_length == '0))
    else $error("empty status with elements in the list");

endmodule
